// ===== src/cfta_pkg.sv =====
package cfta_pkg;

  localparam int DIR_BITS  = 16;
  localparam int SIZE_BITS = 12;
  localparam int FRAC_BITS = 8;

  // config register width holds the face size itself (up to 2**SIZE_BITS)
  localparam int CFG_W = SIZE_BITS + 1;
  localparam int IDX_W = 2;

  localparam int MAG_W = DIR_BITS;
  localparam int DEN_W = DIR_BITS + 1;
  localparam int NUM_W = DEN_W + SIZE_BITS;
  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int REM_W = DEN_W;

  // quotient is the texel coordinate with its fraction, resolved 4 bits per stage
  localparam int Q_W        = SIZE_BITS + FRAC_BITS;
  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = (Q_W + STEP_BITS - 1) / STEP_BITS;
  localparam int Q_PAD      = DIV_STAGES * STEP_BITS;

  localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(1) << SIZE_BITS;

  localparam logic [IDX_W-1:0] REG_FACE_WIDTH   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FACE_HEIGHT  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_USE_BILINEAR = IDX_W'(2);

  localparam logic [CFG_W-1:0] FACE_SIZE_RESET = CFG_W'(256);

  typedef enum logic [2:0] {
    FACE_NEGX = 3'd0,
    FACE_NEGY = 3'd1,
    FACE_NEGZ = 3'd2,
    FACE_POSX = 3'd3,
    FACE_POSY = 3'd4,
    FACE_POSZ = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    face_e                face;
    logic [SIZE_BITS-1:0] texel_x;
    logic [SIZE_BITS-1:0] texel_y;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic                 zero_vector;
  } texel_t;

  // working set of one restoring divider lane
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_PAD-1:0] dvd;
    logic [Q_PAD-1:0] quo;
  } div_t;

  // per-beat side data that rides along the divider stages
  typedef struct packed {
    face_e            face;
    logic             zero;
    logic [DEN_W-1:0] den;
  } side_t;

endpackage

// ===== src/cfta_div_stage.sv =====
module cfta_div_stage (
  input  logic                         clk_i,
  input  cfta_pkg::div_t               stage_i,
  input  logic [cfta_pkg::DEN_W-1:0]   den_i,
  output cfta_pkg::div_t               stage_o
);
  import cfta_pkg::*;

  div_t stage_d;
  div_t stage_q;

  always_comb begin
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    logic [Q_PAD-1:0] d;
    logic [Q_PAD-1:0] q;
    r = stage_i.rem;
    d = stage_i.dvd;
    q = stage_i.quo;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, d[Q_PAD-1]};
      d = {d[Q_PAD-2:0], 1'b0};
      if (t >= {1'b0, den_i}) begin
        t = t - {1'b0, den_i};
        q = {q[Q_PAD-2:0], 1'b1};
      end else begin
        q = {q[Q_PAD-2:0], 1'b0};
      end
      r = t[REM_W-1:0];
    end
    stage_d.rem = r;
    stage_d.dvd = d;
    stage_d.quo = q;
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

endmodule

// ===== src/cubemap_face_texel_address_core.sv =====
// A beat accepted at one edge shows its result with done_o high after it has passed the registers
// select, offset, multiply, five divider stages and output.
// Throughput: one beat per cycle; busy stays low, the result is never held off.
// The divider lanes resolve four quotient bits per stage, and their stage count sets the latency.
// Reset (rst_ni low, async) clears all valid bits and loads the face size 256 x 256, nearest mode.
module cubemap_face_texel_address_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  cfta_pkg::dir_t               dir_i,
  output logic                         done_o,
  output cfta_pkg::texel_t             result_o,
  input  logic                         cfg_we_i,
  input  logic [cfta_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [cfta_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import cfta_pkg::*;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] face_width_q;
  logic [CFG_W-1:0] face_height_q;
  logic             use_bilinear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_width_q   <= FACE_SIZE_RESET;
      face_height_q  <= FACE_SIZE_RESET;
      use_bilinear_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FACE_WIDTH:   face_width_q   <= cfg_wdata_i;
        REG_FACE_HEIGHT:  face_height_q  <= cfg_wdata_i;
        REG_USE_BILINEAR: use_bilinear_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [SIZE_BITS-1:0] size_m1(input logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] t;
    if (s <= CFG_W'(1)) begin
      t = '0;
    end else if (s >= SIZE_MAX) begin
      t = SIZE_MAX - CFG_W'(1);
    end else begin
      t = s - CFG_W'(1);
    end
    return t[SIZE_BITS-1:0];
  endfunction

  logic [SIZE_BITS-1:0] sm1_x;
  logic [SIZE_BITS-1:0] sm1_y;
  assign sm1_x = size_m1(face_width_q);
  assign sm1_y = size_m1(face_height_q);

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: major axis and face ----------------
  logic signed [DIR_BITS:0] xs, ys, zs, nxs, nys, nzs;
  logic [MAG_W-1:0]         ax, ay, az, m_d;
  logic                     neg_d, zero_d;
  logic [1:0]               axis_d;
  face_e                    face_d;
  logic signed [DIR_BITS:0] u_d, v_d;

  always_comb begin
    xs  = {dir_i.dir_x[DIR_BITS-1], dir_i.dir_x};
    ys  = {dir_i.dir_y[DIR_BITS-1], dir_i.dir_y};
    zs  = {dir_i.dir_z[DIR_BITS-1], dir_i.dir_z};
    nxs = -xs;
    nys = -ys;
    nzs = -zs;
    ax  = xs[DIR_BITS] ? nxs[MAG_W-1:0] : xs[MAG_W-1:0];
    ay  = ys[DIR_BITS] ? nys[MAG_W-1:0] : ys[MAG_W-1:0];
    az  = zs[DIR_BITS] ? nzs[MAG_W-1:0] : zs[MAG_W-1:0];
    zero_d = (ax == '0) && (ay == '0) && (az == '0);
    // ties go to the earlier axis
    if (ax >= ay && ax >= az) begin
      axis_d = 2'd0; m_d = ax; neg_d = xs[DIR_BITS];
    end else if (ay >= az) begin
      axis_d = 2'd1; m_d = ay; neg_d = ys[DIR_BITS];
    end else begin
      axis_d = 2'd2; m_d = az; neg_d = zs[DIR_BITS];
    end
    face_d = face_e'((neg_d ? 3'd0 : 3'd3) + {1'b0, axis_d});
    unique case (face_d)
      FACE_NEGX: begin u_d = zs;  v_d = nys; end
      FACE_NEGY: begin u_d = xs;  v_d = nzs; end
      FACE_NEGZ: begin u_d = xs;  v_d = ys;  end
      FACE_POSX: begin u_d = nzs; v_d = nys; end
      FACE_POSY: begin u_d = xs;  v_d = zs;  end
      default:   begin u_d = xs;  v_d = nys; end
    endcase
  end

  logic                     s1_valid_q;
  face_e                    s1_face_q;
  logic                     s1_zero_q;
  logic [MAG_W-1:0]         s1_m_q;
  logic signed [DIR_BITS:0] s1_u_q, s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_face_q <= face_d;
    s1_zero_q <= zero_d;
    s1_m_q    <= m_d;
    s1_u_q    <= u_d;
    s1_v_q    <= v_d;
  end

  // ---------------- stage 2: offsets c + m and divisor 2m ----------------
  logic signed [DIR_BITS+1:0] sum_u, sum_v, m_ext;
  assign m_ext = $signed({2'b00, s1_m_q});
  assign sum_u = {s1_u_q[DIR_BITS], s1_u_q} + m_ext;
  assign sum_v = {s1_v_q[DIR_BITS], s1_v_q} + m_ext;

  logic             s2_valid_q;
  face_e            s2_face_q;
  logic             s2_zero_q;
  logic [DEN_W-1:0] s2_den_q, s2_off_u_q, s2_off_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_face_q  <= s1_face_q;
    s2_zero_q  <= s1_zero_q;
    s2_den_q   <= {s1_m_q, 1'b0};
    s2_off_u_q <= sum_u[DEN_W-1:0];
    s2_off_v_q <= sum_v[DEN_W-1:0];
  end

  // ---------------- stage 3: numerators ----------------
  logic [NUM_W-1:0] prod_u, prod_v;
  assign prod_u = s2_off_u_q * sm1_x;
  assign prod_v = s2_off_v_q * sm1_y;

  logic [NUM_W-1:0]    s3_num_u_q, s3_num_v_q;
  logic [DIV_STAGES:0] dv_q;
  side_t               side_q [DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[DIV_STAGES-1:0], s2_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    s3_num_u_q     <= prod_u;
    s3_num_v_q     <= prod_v;
    side_q[0].face <= s2_face_q;
    side_q[0].zero <= s2_zero_q;
    side_q[0].den  <= s2_den_q;
    for (int k = 0; k < DIV_STAGES; k++) begin
      side_q[k+1] <= side_q[k];
    end
  end

  // ---------------- divider lanes: num * 2^FRAC_BITS / 2m ----------------
  logic [DVD_W-1:0] dvd_u, dvd_v;
  assign dvd_u = {s3_num_u_q, {FRAC_BITS{1'b0}}};
  assign dvd_v = {s3_num_v_q, {FRAC_BITS{1'b0}}};

  div_t div_u [DIV_STAGES+1];
  div_t div_v [DIV_STAGES+1];

  // for a nonzero vector, bits above the quotient field are always below the divisor
  assign div_u[0].rem = REM_W'(dvd_u >> Q_PAD);
  assign div_u[0].dvd = dvd_u[Q_PAD-1:0];
  assign div_u[0].quo = '0;
  assign div_v[0].rem = REM_W'(dvd_v >> Q_PAD);
  assign div_v[0].dvd = dvd_v[Q_PAD-1:0];
  assign div_v[0].quo = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    cfta_div_stage u_div_u (
      .clk_i   (clk_i),
      .stage_i (div_u[k]),
      .den_i   (side_q[k].den),
      .stage_o (div_u[k+1])
    );
    cfta_div_stage u_div_v (
      .clk_i   (clk_i),
      .stage_i (div_v[k]),
      .den_i   (side_q[k].den),
      .stage_o (div_v[k+1])
    );
  end

  // ---------------- output register ----------------
  logic [Q_PAD-1:0] quo_u, quo_v;
  assign quo_u = div_u[DIV_STAGES].quo;
  assign quo_v = div_v[DIV_STAGES].quo;

  texel_t res_d, res_q;
  logic   done_q;

  always_comb begin
    res_d.face        = side_q[DIV_STAGES].face;
    res_d.texel_x     = quo_u[Q_W-1:FRAC_BITS];
    res_d.texel_y     = quo_v[Q_W-1:FRAC_BITS];
    res_d.frac_x      = use_bilinear_q ? quo_u[FRAC_BITS-1:0] : '0;
    res_d.frac_y      = use_bilinear_q ? quo_v[FRAC_BITS-1:0] : '0;
    res_d.zero_vector = side_q[DIV_STAGES].zero;
    if (side_q[DIV_STAGES].zero) begin
      res_d.face    = FACE_NEGX;
      res_d.texel_x = '0;
      res_d.texel_y = '0;
      res_d.frac_x  = '0;
      res_d.frac_y  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(dv_q[0], DIV_STAGES + 1))
    else $error("result strobe out of step with divider entry");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DIV_STAGES] && !side_q[DIV_STAGES].zero |->
      div_u[DIV_STAGES].rem < side_q[DIV_STAGES].den &&
      div_v[DIV_STAGES].rem < side_q[DIV_STAGES].den)
    else $error("divider remainder not below divisor");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.zero_vector |->
      result_o.face == FACE_NEGX && result_o.texel_x == '0 && result_o.texel_y == '0 &&
      result_o.frac_x == '0 && result_o.frac_y == '0)
    else $error("zero vector beat carries nonzero fields");

  a_nearest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(!use_bilinear_q) |-> result_o.frac_x == '0 && result_o.frac_y == '0)
    else $error("fraction present in nearest mode");

endmodule

// ===== tb/cubemap_face_texel_address_checker.sv =====
`timescale 1ns / 100ps

module cubemap_face_texel_address_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  cfta_pkg::dir_t             dir_i,
  input  logic                       done_i,
  input  cfta_pkg::texel_t           result_i,
  input  logic                       cfg_we_i,
  input  logic [cfta_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [cfta_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                         pending_o,
  output int                         checked_o,
  output int                         fail_cnt_o
);
  import cfta_pkg::*;

  localparam face_e NEG_FACE [3] = '{FACE_NEGX, FACE_NEGY, FACE_NEGZ};
  localparam face_e POS_FACE [3] = '{FACE_POSX, FACE_POSY, FACE_POSZ};

  logic [CFG_W-1:0] face_w = FACE_SIZE_RESET;
  logic [CFG_W-1:0] face_h = FACE_SIZE_RESET;
  logic             bilinear = 1'b0;
  texel_t           texel_q [$];
  texel_t           want;

  // (c + m) * (size - 1) / 2m, integer part plus truncated fraction
  function automatic void project_axis(input longint c, input longint m, input longint size_reg,
                                       output logic [SIZE_BITS-1:0] ipart,
                                       output logic [FRAC_BITS-1:0] fpart);
    longint sz;
    longint den;
    longint num;
    longint rem;
    sz = size_reg;
    if (sz == 0) begin
      sz = 1;
    end else if (sz > longint'(SIZE_MAX)) begin
      sz = longint'(SIZE_MAX);
    end
    den = 2 * m;
    num = (c + m) * (sz - 1);
    rem = num % den;
    ipart = SIZE_BITS'(num / den);
    fpart = FRAC_BITS'((rem << FRAC_BITS) / den);
  endfunction

  function automatic texel_t predict_texel(dir_t d, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                           logic bil);
    longint x, y, z, ax, ay, az, m, comp, u, v;
    int axis;
    logic [SIZE_BITS-1:0] tx, ty;
    logic [FRAC_BITS-1:0] fx, fy;
    texel_t t;
    t = '0;
    x = $signed(d.dir_x);
    y = $signed(d.dir_y);
    z = $signed(d.dir_z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    if (ax == 0 && ay == 0 && az == 0) begin
      t.zero_vector = 1'b1;
      return t;
    end
    // ties go to the earlier axis
    if (ax >= ay && ax >= az) begin
      axis = 0; m = ax; comp = x;
    end else if (ay >= az) begin
      axis = 1; m = ay; comp = y;
    end else begin
      axis = 2; m = az; comp = z;
    end
    if (comp < 0) begin
      t.face = NEG_FACE[axis];
    end else begin
      t.face = POS_FACE[axis];
    end
    case (t.face)
      FACE_NEGX: begin u = z;  v = -y; end
      FACE_NEGY: begin u = x;  v = -z; end
      FACE_NEGZ: begin u = x;  v = y;  end
      FACE_POSX: begin u = -z; v = -y; end
      FACE_POSY: begin u = x;  v = z;  end
      default:   begin u = x;  v = -y; end
    endcase
    project_axis(u, m, longint'(w), tx, fx);
    project_axis(v, m, longint'(h), ty, fy);
    t.texel_x = tx;
    t.texel_y = ty;
    t.frac_x  = bil ? fx : '0;
    t.frac_y  = bil ? fy : '0;
    return t;
  endfunction

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_w = FACE_SIZE_RESET;
      face_h = FACE_SIZE_RESET;
      bilinear = 1'b0;
      texel_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (texel_q.size() == 0) begin
          $error("result beat with nothing outstanding (face %0d)", result_i.face);
          fail_cnt_o++;
        end else begin
          want = texel_q.pop_front();
          checked_o++;
          check_field("face", want.face, result_i.face);
          check_field("texel_x", want.texel_x, result_i.texel_x);
          check_field("texel_y", want.texel_y, result_i.texel_y);
          check_field("frac_x", want.frac_x, result_i.frac_x);
          check_field("frac_y", want.frac_y, result_i.frac_y);
          check_field("zero_vector", want.zero_vector, result_i.zero_vector);
        end
      end
      // config only moves while idle, so the pre-edge settings apply here
      if (start_i && !busy_i) begin
        texel_q.push_back(predict_texel(dir_i, face_w, face_h, bilinear));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FACE_WIDTH:   face_w = cfg_wdata_i;
          REG_FACE_HEIGHT:  face_h = cfg_wdata_i;
          REG_USE_BILINEAR: bilinear = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o <= texel_q.size();
    end
  end

endmodule

// ===== tb/cubemap_face_texel_address_core_test.sv =====
`timescale 1ns / 100ps

module cubemap_face_texel_address_core_test;
  import cfta_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);
  localparam int RAND_BEATS = 215;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  dir_t             dir_i;
  logic             done_o;
  texel_t           result_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  int pending;
  int checked;
  int fail_cnt;
  int n_sent;
  int n_settings;
  int calm_left;

  cubemap_face_texel_address_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .dir_i       (dir_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  cubemap_face_texel_address_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .dir_i       (dir_i),
    .done_i      (done_o),
    .result_i    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .checked_o   (checked),
    .fail_cnt_o  (fail_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic dir_t make_dir(int x, int y, int z);
    dir_t d;
    d.dir_x = DIR_BITS'(x);
    d.dir_y = DIR_BITS'(y);
    d.dir_z = DIR_BITS'(z);
    return d;
  endfunction

  function automatic int flip(int m);
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic dir_t rand_dir();
    int kind, m, a, b;
    int c [3];
    kind = $urandom_range(0, 9);
    m = $urandom_range(1, 32768);
    a = $urandom_range(0, 2);
    b = (a + 1 + $urandom_range(0, 1)) % 3;
    for (int i = 0; i < 3; i++) begin
      c[i] = $urandom_range(0, 2 * m) - m;
    end
    case (kind)
      0, 1, 2, 3: begin
        c[0] = $urandom; c[1] = $urandom; c[2] = $urandom;
      end
      4: begin
        for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 6) - 3;
      end
      5: begin
        // two-way magnitude tie, third component below or equal
        c[a] = flip(m);
        c[b] = flip(m);
      end
      6: begin
        c[a] = $urandom_range(0, 1) ? 32767 : -32768;
        c[b] = $urandom_range(0, 65534) - 32767;
        c[3 - a - b] = $urandom_range(0, 65534) - 32767;
      end
      7: begin
        // minor components each pinned to the face border or not, at random
        c[a] = flip(m);
        if ($urandom_range(0, 1)) c[b] = flip(m);
        if ($urandom_range(0, 1)) c[3 - a - b] = flip(m);
      end
      default: begin
        for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 2000) - 1000;
      end
    endcase
    return make_dir(c[0], c[1], c[2]);
  endfunction

  task automatic send_dir(dir_t d, bit gaps);
    int n;
    if (gaps) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 29) == 0) begin
        calm_left = $urandom_range(20, 60);
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 13);
        start <= 1'b0;
        dir_i <= rand_dir();
        repeat (n) @(posedge clk_i);
      end
    end
    start <= 1'b1;
    dir_i <= d;
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] bil,
                           bit spare);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FACE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FACE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_idx_i   <= REG_USE_BILINEAR;
    cfg_wdata_i <= bil;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i   <= REG_SPARE;
      cfg_wdata_i <= CFG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    #2_000_000;
    $display("cubemap_face_texel_address_core verification failed");
    $finish;
  end

  initial begin
    int corners [20][3] = '{
      '{0, 0, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0},
      '{0, 0, 1}, '{0, 0, -1}, '{-32768, -32768, -32768}, '{32767, -32768, 0},
      '{-32768, 32767, 32767}, '{5, 5, 0}, '{0, -7, 7}, '{100, -100, -100},
      '{32767, -32767, -32767}, '{1, 1, 1}, '{-1, -1, -1}, '{32767, 0, 0},
      '{12345, -6789, 321}, '{-3, 2, -1}, '{-20000, 32767, -32768}
    };
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    dir_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_FACE_WIDTH;
    cfg_wdata_i <= '0;
    n_settings  = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 256 x 256, nearest
    foreach (corners[i]) send_dir(make_dir(corners[i][0], corners[i][1], corners[i][2]), 1'b1);
    repeat (RAND_BEATS / 2) send_dir(rand_dir(), 1'b1);
    settle();
    repeat (RAND_BEATS / 2) send_dir(rand_dir(), 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: configure(CFG_W'(4096), CFG_W'(4096), CFG_W'(1), 1'b0);
        1: configure(CFG_W'(1), CFG_W'(1), 13'h0001, 1'b0);
        2: configure(CFG_W'(0), CFG_W'(8191), CFG_W'(1), 1'b0);
        // bit 0 clear with junk above it: nearest mode
        3: configure(CFG_W'(5000), CFG_W'(0), 13'h1ffe, 1'b0);
        4: configure(CFG_W'($urandom_range(2, 4096)), CFG_W'($urandom_range(2, 4096)),
                     CFG_W'(1), 1'b1);
        default: configure(CFG_W'(3), CFG_W'(4096), CFG_W'(1), 1'b0);
      endcase
      repeat (RAND_BEATS) send_dir(rand_dir(), p != 5);
    end

    settle();
    repeat (12) @(posedge clk_i);
    $display("run covered %0d direction beats over %0d size/filter settings,",
             n_sent, n_settings);
    $display("with %0d results compared field by field", checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("cubemap_face_texel_address_core verification clean");
    end else begin
      $display("cubemap_face_texel_address_core verification failed");
    end
    $finish;
  end

endmodule
